>>> src/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg
// Shared types and constants for the id queue with removal by key.
// ----------------------------------------------------------------------------
package idq_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int ID_WIDTH_DEF = 16;
	localparam int ID_MAX_W     = 32;
	localparam int ITEM_ID_W    = 16;
	localparam int OCC_W        = 5;

	typedef enum logic [1:0] {
		ACT_ENQ  = 2'd0,
		ACT_DEQ  = 2'd1,
		ACT_REM  = 2'd2,
		ACT_PEEK = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} fsm_t;

	typedef struct packed {
		action_t                action;
		logic [ITEM_ID_W-1:0]   item_id;
	} req_t;

	typedef struct packed {
		logic [ITEM_ID_W-1:0]   out_id;
		logic                   out_valid;
		logic [OCC_W-1:0]       occupancy;
		status_t                status;
	} rsp_t;

endpackage

>>> src/idq_ram.sv
// ----------------------------------------------------------------------------
// idq_ram
// Single write port, single read port entry store with registered read data.
// ----------------------------------------------------------------------------
module idq_ram #(
	parameter int DEPTH    = idq_pkg::DEPTH_DEF,
	parameter int ID_WIDTH = idq_pkg::ID_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [ID_WIDTH-1:0]      wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [ID_WIDTH-1:0]      rdata
);

	logic [ID_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/id_fifo_with_removal.sv
// ----------------------------------------------------------------------------
// id_fifo_with_removal
// Bounded first-in first-out queue of ids with enqueue, dequeue, peek and
// removal of the first matching id, gap closed in place.
// ----------------------------------------------------------------------------
// enqueue goes straight to the result; dequeue and peek first read the head entry
// (not on an empty queue); remove does one ram read per cycle: scan to the match,
// then one shift per entry
// one item is in flight at a time; the next is taken once the result is queued
// in the output register, which can hold while the next item is accepted
// reset clears count, head and control state; entries stay unwritten
// ----------------------------------------------------------------------------
module id_fifo_with_removal #(
	parameter int DEPTH    = idq_pkg::DEPTH_DEF,
	parameter int ID_WIDTH = idq_pkg::ID_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  idq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output idq_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = CW + 1;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	idq_pkg::fsm_t           state_q, state_d;
	logic [AW-1:0]           head_q, head_d;
	logic [CW-1:0]           count_q, count_d;
	idq_pkg::action_t        act_q, act_d;
	logic [ID_WIDTH-1:0]     id_q, id_d;
	logic [CW-1:0]           idx_q, idx_d;
	logic [AW-1:0]           ptr_q, ptr_d;
	logic [ID_WIDTH-1:0]     res_id_q, res_id_d;
	logic                    res_valid_q, res_valid_d;
	idq_pkg::status_t        res_status_q, res_status_d;
	idq_pkg::rsp_t           out_q;
	logic                    out_full_q;
	logic                    out_load;

	logic                    we;
	logic [AW-1:0]           waddr;
	logic [ID_WIDTH-1:0]     wdata;
	logic [AW-1:0]           raddr;
	logic [ID_WIDTH-1:0]     rdata;

	logic [idq_pkg::ID_MAX_W-1:0] id_ext;
	logic [idq_pkg::ID_MAX_W-1:0] res_ext;
	logic [idq_pkg::ID_MAX_W-1:0] count_ext;
	logic [ID_WIDTH-1:0]     id_in;
	logic [TW-1:0]           tail_sum;
	logic [AW-1:0]           tail;
	logic                    accept;
	logic                    scan_last;
	logic                    shift_last;
	logic                    hit;
	logic [AW-1:0]           nptr;

	assign id_ext     = idq_pkg::ID_MAX_W'(req.item_id);
	assign id_in      = id_ext[ID_WIDTH-1:0];
	assign tail_sum   = TW'(head_q) + TW'(count_q);
	assign tail       = (tail_sum >= TW'(DEPTH)) ? AW'(tail_sum - TW'(DEPTH)) : AW'(tail_sum);
	assign req_stall  = state_q != idq_pkg::S_IDLE;
	assign accept     = req_valid && !req_stall;
	assign scan_last  = (idx_q + CW'(1)) == count_q;
	assign shift_last = (idx_q + CW'(2)) == count_q;
	assign hit        = rdata == id_q;
	assign nptr       = ptr_inc(ptr_q);
	assign out_load   = (state_q == idq_pkg::S_FINISH) && (!out_full_q || !rsp_stall);

	idq_ram #(
		.DEPTH    (DEPTH),
		.ID_WIDTH (ID_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			idq_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req.action == idq_pkg::ACT_ENQ || count_q == '0) begin
						state_d = idq_pkg::S_FINISH;
					end else if (req.action == idq_pkg::ACT_REM) begin
						state_d = idq_pkg::S_SCAN;
					end else begin
						state_d = idq_pkg::S_HEAD;
					end
				end
			end
			idq_pkg::S_HEAD: begin
				state_d = idq_pkg::S_FINISH;
			end
			idq_pkg::S_SCAN: begin
				if (scan_last) begin
					state_d = idq_pkg::S_FINISH;
				end else if (hit) begin
					state_d = idq_pkg::S_SHIFT;
				end
			end
			idq_pkg::S_SHIFT: begin
				if (shift_last) begin
					state_d = idq_pkg::S_FINISH;
				end
			end
			idq_pkg::S_FINISH: begin
				if (!out_full_q || !rsp_stall) begin
					state_d = idq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = idq_pkg::S_IDLE;
			end
		endcase
	end

	// datapath and ram control
	always_comb begin
		we           = 1'b0;
		waddr        = ptr_q;
		wdata        = rdata;
		raddr        = head_q;
		head_d       = head_q;
		count_d      = count_q;
		act_d        = act_q;
		id_d         = id_q;
		idx_d        = idx_q;
		ptr_d        = ptr_q;
		res_id_d     = res_id_q;
		res_valid_d  = res_valid_q;
		res_status_d = res_status_q;
		case (state_q)
			idq_pkg::S_IDLE: begin
				act_d        = req.action;
				id_d         = id_in;
				idx_d        = '0;
				ptr_d        = head_q;
				res_id_d     = '0;
				res_valid_d  = 1'b0;
				res_status_d = idq_pkg::ST_OK;
				if (accept) begin
					if (req.action == idq_pkg::ACT_ENQ) begin
						if (count_q == CW'(DEPTH)) begin
							res_status_d = idq_pkg::ST_FULL;
						end else begin
							we      = 1'b1;
							waddr   = tail;
							wdata   = id_in;
							count_d = count_q + CW'(1);
						end
					end else if (count_q == '0) begin
						res_status_d = idq_pkg::ST_EMPTY;
					end
				end
			end
			idq_pkg::S_HEAD: begin
				res_id_d    = rdata;
				res_valid_d = 1'b1;
				if (act_q == idq_pkg::ACT_DEQ) begin
					head_d  = ptr_inc(head_q);
					count_d = count_q - CW'(1);
				end
			end
			idq_pkg::S_SCAN: begin
				raddr = nptr;
				if (hit) begin
					if (scan_last) begin
						count_d = count_q - CW'(1);
					end
				end else if (scan_last) begin
					res_status_d = idq_pkg::ST_MISSING;
				end else begin
					ptr_d = nptr;
					idx_d = idx_q + CW'(1);
				end
			end
			idq_pkg::S_SHIFT: begin
				we    = 1'b1;
				waddr = ptr_q;
				wdata = rdata;
				raddr = ptr_inc(nptr);
				ptr_d = nptr;
				idx_d = idx_q + CW'(1);
				if (shift_last) begin
					count_d = count_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= idq_pkg::S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_full_q <= 1'b0;
			end
		end
	end

	assign res_ext   = idq_pkg::ID_MAX_W'(res_id_q);
	assign count_ext = idq_pkg::ID_MAX_W'(count_q);

	always_ff @(posedge clk) begin
		act_q        <= act_d;
		id_q         <= id_d;
		idx_q        <= idx_d;
		ptr_q        <= ptr_d;
		res_id_q     <= res_id_d;
		res_valid_q  <= res_valid_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_q.out_id    <= res_ext[idq_pkg::ITEM_ID_W-1:0];
			out_q.out_valid <= res_valid_q;
			out_q.occupancy <= count_ext[idq_pkg::OCC_W-1:0];
			out_q.status    <= res_status_q;
		end
	end

	assign rsp_valid = out_full_q;
	assign rsp       = out_q;

endmodule

>>> src/idq_chk.sv
// ----------------------------------------------------------------------------
// idq_chk
// Port level checks for the id queue, bound to the top level.
// ----------------------------------------------------------------------------
module idq_chk #(
	parameter int DEPTH = idq_pkg::DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input idq_pkg::rsp_t rsp
);

	// a stalled result item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	// no id means a zero id and a non-ok status only without an id
	a_no_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.out_valid |-> rsp.out_id == '0)
		else $error("out_id not zero without an id");

	a_id_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_valid |-> rsp.status == idq_pkg::ST_OK)
		else $error("id returned with a failing status");

	// occupancy agrees with empty and full reports and, below a depth of 32, stays within DEPTH
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			(rsp.status != idq_pkg::ST_EMPTY || rsp.occupancy == '0) &&
			(rsp.status != idq_pkg::ST_FULL || rsp.occupancy == idq_pkg::OCC_W'(DEPTH)) &&
			(DEPTH > 31 || 32'(rsp.occupancy) <= DEPTH))
		else $error("occupancy inconsistent with status");

endmodule

bind id_fifo_with_removal idq_chk #(
	.DEPTH (DEPTH)
) u_idq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
